[rtl/core/dns_catchall_a_responder_defines.svh]
// assertion macros shared by the checker
`ifndef DNS_CATCHALL_A_RESPONDER_DEFINES_SVH
`define DNS_CATCHALL_A_RESPONDER_DEFINES_SVH

// consequent in the cycle after the antecedent
`define DCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent in the same cycle as the antecedent
`define DCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/dca_pkg.sv]
package dca_pkg;

  // packet buffer
  localparam int BUF_DEPTH = 256;
  localparam int AW        = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int QE_W      = $clog2(BUF_DEPTH + 256);
  localparam int SUM_W     = QE_W + 1;

  localparam int HEADER_BYTES  = 12;
  localparam int ANSWER_BYTES  = 16;
  localparam int QTAIL_BYTES   = 5;
  localparam int HDR_FIX_BYTES = 8;
  localparam int FILL_LEN      = HDR_FIX_BYTES + ANSWER_BYTES;
  localparam int FILL_W        = $clog2(FILL_LEN);

  // answer constants
  localparam logic [7:0] FLAGS_HI = 8'h81;
  localparam logic [7:0] FLAGS_LO = 8'h80;
  localparam logic [7:0] PTR_HI   = 8'hC0;
  localparam logic [7:0] PTR_LO   = 8'h0C;
  localparam logic [7:0] RDLEN_LO = 8'h04;

  localparam logic [31:0] IPV4_RESET = 32'hC0A8_0401;
  localparam logic [15:0] TTL_RESET  = 16'd60;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 32;
  localparam logic [CFG_IDX_W-1:0] REG_IPV4 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TTL  = 2'd1;

  // operations
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  typedef enum logic [2:0] {
    ST_TAKEN     = 3'd0,
    ST_READY     = 3'd1,
    ST_SHORT     = 3'd2,
    ST_NO_ROOM   = 3'd3,
    ST_RESP_BYTE = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef struct packed {
    logic       func;
    logic [7:0] query_byte;
    logic       query_last;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [8:0] response_length;
    logic [7:0] response_byte;
    logic       response_last;
  } out_item_t;

endpackage

[rtl/core/dns_catchall_a_responder.sv]
// catch-all dns responder: every query that fits is answered with one a record. query bytes are
// pushed one per transfer (func 0) and the response is pulled one byte per transfer
// (func 1). every accepted item gives exactly one result, on out_data with out_strobe
// high, in the cycle after acceptance; the receiver cannot stall it and must take it
// then. pushes and pulls may follow back to back while busy is low. the final push
// of a query that fits keeps busy high while the header fields and the 16-byte
// answer are written into the packet buffer through its single write port; the
// answer carries the address and ttl held at that final push. after reset busy
// stays high while all BUF_DEPTH entries of the buffer are cleared, one entry a cycle;
// configuration writes are taken during that time as always.
module dns_catchall_a_responder
  import dca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_strobe,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL
  } state_t;

  // control state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [FILL_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [AW-1:0]     fill_base_r, fill_base_nxt;
  logic [15:0]       fill_ttl_r, fill_ttl_nxt;
  logic [31:0]       fill_ip_r, fill_ip_nxt;

  // packet tracking
  logic [CNT_W-1:0]  rcv_cnt_r, rcv_cnt_nxt;
  logic [QE_W-1:0]   qend_r, qend_nxt;
  logic              walk_done_r, walk_done_nxt;
  logic [CNT_W-1:0]  ready_len_r, ready_len_nxt;
  logic [CNT_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic              resp_ready_r, resp_ready_nxt;

  // configuration
  logic [31:0]       ipv4_r, ipv4_nxt;
  logic [15:0]       ttl_r, ttl_nxt;

  // result registers
  logic              out_strobe_r, out_strobe_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [8:0]        out_len_r, out_len_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_bsel_r, out_bsel_nxt;

  // buffer port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  // working values
  logic              accept;
  logic              rx_ok;
  logic [CNT_W-1:0]  rcv_after;
  logic [QE_W-1:0]   qend_after;
  logic              walk_after;
  logic [SUM_W-1:0]  ans_pos;
  logic [SUM_W-1:0]  ans_end;
  logic              pull_ok;
  logic [CNT_W-1:0]  rd_pos_inc;
  logic [3:0]        ans_idx;

  dca_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // push bookkeeping: byte store and incremental label walk
  always_comb begin
    rx_ok      = (rcv_cnt_r < CNT_W'(BUF_DEPTH));
    rcv_after  = rcv_cnt_r;
    qend_after = qend_r;
    walk_after = walk_done_r;
    if (rx_ok) begin
      rcv_after = rcv_cnt_r + CNT_W'(1);
      if (!walk_done_r && (QE_W'(rcv_cnt_r) == qend_r)) begin
        if (in_data.query_byte == 8'h00) begin
          walk_after = 1'b1;
        end else begin
          qend_after = qend_r + QE_W'(in_data.query_byte) + QE_W'(1);
        end
      end
    end
    // answer starts after qtype and qclass
    ans_pos = SUM_W'(qend_after) + SUM_W'(QTAIL_BYTES);
    ans_end = ans_pos + SUM_W'(ANSWER_BYTES);
  end

  // pull bookkeeping
  always_comb begin
    pull_ok    = resp_ready_r && (rd_pos_r < ready_len_r) &&
                 (rd_pos_r < CNT_W'(BUF_DEPTH));
    rd_pos_inc = rd_pos_r + CNT_W'(1);
  end

  // answer byte position within the fill sequence
  assign ans_idx = 4'(fill_cnt_r - FILL_W'(HDR_FIX_BYTES));

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    fill_cnt_nxt   = fill_cnt_r;
    fill_base_nxt  = fill_base_r;
    fill_ttl_nxt   = fill_ttl_r;
    fill_ip_nxt    = fill_ip_r;
    rcv_cnt_nxt    = rcv_cnt_r;
    qend_nxt       = qend_r;
    walk_done_nxt  = walk_done_r;
    ready_len_nxt  = ready_len_r;
    rd_pos_nxt     = rd_pos_r;
    resp_ready_nxt = resp_ready_r;
    ipv4_nxt       = ipv4_r;
    ttl_nxt        = ttl_r;
    out_strobe_nxt = accept;
    out_status_nxt = ST_TAKEN;
    out_len_nxt    = 9'd0;
    out_last_nxt   = 1'b0;
    out_bsel_nxt   = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = rcv_cnt_r[AW-1:0];
    ram_wdata      = in_data.query_byte;
    ram_raddr      = rd_pos_r[AW-1:0];

    // register writes, taken in any state
    if (cfg_we) begin
      case (cfg_index)
        REG_IPV4: ipv4_nxt = cfg_wdata;
        REG_TTL:  ttl_nxt  = cfg_wdata[15:0];
        default:  ;
      endcase
    end

    case (state_r)
      S_CLEAR: begin
        // zero the buffer one entry a cycle
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r[AW-1:0];
        ram_wdata   = 8'h00;
        clr_cnt_nxt = clr_cnt_r + CNT_W'(1);
        if (clr_cnt_r == CNT_W'(BUF_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept && (in_data.func == FUNC_PUSH)) begin
          resp_ready_nxt = 1'b0;
          ram_we         = rx_ok;
          rcv_cnt_nxt    = rcv_after;
          qend_nxt       = qend_after;
          walk_done_nxt  = walk_after;
          if (in_data.query_last) begin
            if (rcv_after < CNT_W'(HEADER_BYTES)) begin
              out_status_nxt = ST_SHORT;
            end else if (ans_end > SUM_W'(BUF_DEPTH)) begin
              out_status_nxt = ST_NO_ROOM;
            end else begin
              // answer fits: rewrite header and append the record
              fill_base_nxt  = ans_pos[AW-1:0];
              fill_ttl_nxt   = ttl_r;
              fill_ip_nxt    = ipv4_r;
              ready_len_nxt  = ans_end[CNT_W-1:0];
              rd_pos_nxt     = '0;
              resp_ready_nxt = 1'b1;
              out_status_nxt = ST_READY;
              out_len_nxt    = 9'(ans_end);
              fill_cnt_nxt   = '0;
              state_nxt      = S_FILL;
            end
            // next packet starts fresh
            rcv_cnt_nxt   = '0;
            qend_nxt      = QE_W'(HEADER_BYTES);
            walk_done_nxt = 1'b0;
          end
        end else if (accept) begin
          if (!pull_ok) begin
            resp_ready_nxt = 1'b0;
            out_status_nxt = ST_NONE;
          end else begin
            // byte comes out of the buffer read register next cycle
            out_status_nxt = ST_RESP_BYTE;
            out_bsel_nxt   = 1'b1;
            rd_pos_nxt     = rd_pos_inc;
            if (rd_pos_inc >= ready_len_r) begin
              out_last_nxt   = 1'b1;
              resp_ready_nxt = 1'b0;
            end
          end
        end
      end

      S_FILL: begin
        ram_we = 1'b1;
        if (fill_cnt_r < FILL_W'(HDR_FIX_BYTES)) begin
          // header: flags, ancount, nscount, arcount
          case (fill_cnt_r[2:0])
            3'd0:    begin ram_waddr = AW'(2);  ram_wdata = FLAGS_HI; end
            3'd1:    begin ram_waddr = AW'(3);  ram_wdata = FLAGS_LO; end
            3'd2:    begin ram_waddr = AW'(6);  ram_wdata = 8'h00;    end
            3'd3:    begin ram_waddr = AW'(7);  ram_wdata = 8'h01;    end
            3'd4:    begin ram_waddr = AW'(8);  ram_wdata = 8'h00;    end
            3'd5:    begin ram_waddr = AW'(9);  ram_wdata = 8'h00;    end
            3'd6:    begin ram_waddr = AW'(10); ram_wdata = 8'h00;    end
            default: begin ram_waddr = AW'(11); ram_wdata = 8'h00;    end
          endcase
        end else begin
          // answer record: name pointer, type a, class in, ttl, rdlength, address
          ram_waddr = fill_base_r + AW'(ans_idx);
          case (ans_idx)
            4'd0:    ram_wdata = PTR_HI;
            4'd1:    ram_wdata = PTR_LO;
            4'd3:    ram_wdata = 8'h01;
            4'd5:    ram_wdata = 8'h01;
            4'd8:    ram_wdata = fill_ttl_r[15:8];
            4'd9:    ram_wdata = fill_ttl_r[7:0];
            4'd11:   ram_wdata = RDLEN_LO;
            4'd12:   ram_wdata = fill_ip_r[31:24];
            4'd13:   ram_wdata = fill_ip_r[23:16];
            4'd14:   ram_wdata = fill_ip_r[15:8];
            4'd15:   ram_wdata = fill_ip_r[7:0];
            default: ram_wdata = 8'h00;
          endcase
        end
        fill_cnt_nxt = fill_cnt_r + FILL_W'(1);
        if (fill_cnt_r == FILL_W'(FILL_LEN - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      fill_cnt_r   <= '0;
      rcv_cnt_r    <= '0;
      qend_r       <= QE_W'(HEADER_BYTES);
      walk_done_r  <= 1'b0;
      ready_len_r  <= '0;
      rd_pos_r     <= '0;
      resp_ready_r <= 1'b0;
      ipv4_r       <= IPV4_RESET;
      ttl_r        <= TTL_RESET;
      out_strobe_r <= 1'b0;
      out_bsel_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      rcv_cnt_r    <= rcv_cnt_nxt;
      qend_r       <= qend_nxt;
      walk_done_r  <= walk_done_nxt;
      ready_len_r  <= ready_len_nxt;
      rd_pos_r     <= rd_pos_nxt;
      resp_ready_r <= resp_ready_nxt;
      ipv4_r       <= ipv4_nxt;
      ttl_r        <= ttl_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_bsel_r   <= out_bsel_nxt;
    end
    // fill context and result payload, without reset
    fill_base_r  <= fill_base_nxt;
    fill_ttl_r   <= fill_ttl_nxt;
    fill_ip_r    <= fill_ip_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe               = out_strobe_r;
  assign out_data.status          = out_status_r;
  assign out_data.response_length = out_len_r;
  assign out_data.response_byte   = out_bsel_r ? ram_rdata : 8'h00;
  assign out_data.response_last   = out_last_r;

endmodule

[rtl/core/dca_ram.sv]
module dca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/dca_checker.sv]
`include "dns_catchall_a_responder_defines.svh"

module dca_checker
  import dca_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_data
);

  logic taken;
  logic other_strobe;
  logic byte_clear;
  logic ready_strobe;
  logic len_match;

  assign taken        = start && !busy;
  assign other_strobe = out_strobe && (out_data.status != ST_RESP_BYTE);
  assign byte_clear   = (out_data.response_byte == 8'h00) && !out_data.response_last;
  assign ready_strobe = out_strobe && (out_data.status == ST_READY);
  assign len_match    = (out_data.status == ST_READY) == (out_data.response_length != 9'd0);

  `DCA_ASSERT_NEXT(a_result_follows, taken, out_strobe, "no result after transfer")

  `DCA_ASSERT_NEXT(a_no_stray_result, !taken, !out_strobe, "result without transfer")

  `DCA_ASSERT_NOW(a_byte_only_on_read, other_strobe, byte_clear, "stray byte fields")

  `DCA_ASSERT_NOW(a_length_on_ready, out_strobe, len_match, "length does not match status")

  `DCA_ASSERT_NEXT(a_busy_after_ready, ready_strobe, busy, "answer write not in progress")

endmodule

bind dns_catchall_a_responder dca_checker u_dca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
